>>> hw/rtl/palette_shade_nearest_match_top_macros.svh
// assertion macros for the palette shade block
`ifndef PALETTE_SHADE_NEAREST_MATCH_TOP_MACROS_SVH
`define PALETTE_SHADE_NEAREST_MATCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PSNM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("palette shade assertion failed");
`define PSNM_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("palette shade assertion failed");
`else
`define PSNM_ASSERT(name, clk, rst_n, prop)
`define PSNM_ASSERT_NEXT(name, clk, rst_n, cond, prop)
`endif
`endif

>>> hw/rtl/psnm_pkg.sv
// types, constants and helpers for the palette shade block
package psnm_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned COL_W = 8;
  localparam int unsigned DIST_W = 10;
  localparam int unsigned DIV3_MUL = 683;
  localparam int unsigned DIV3_SH = 11;
  localparam logic [COL_W-1:0] BLUE_LIFT = 8'd30;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_REBUILD = 2'd1,
    ACT_SHADE   = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_DARKEN,
    ST_SCAN
  } state_e;

  typedef struct packed {
    action_e          action;
    logic [7:0]       index;
    logic [COL_W-1:0] red_in;
    logic [COL_W-1:0] green_in;
    logic [COL_W-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0]       shade_index;
    logic [COL_W-1:0] red_out;
    logic [COL_W-1:0] green_out;
    logic [COL_W-1:0] blue_out;
  } out_t;

  typedef struct packed {
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
  } rgb_t;

  // floor(c * 8 / 12) as floor(2c / 3) by reciprocal multiply
  function automatic logic [COL_W-1:0] darken(input logic [COL_W-1:0] c);
    logic [19:0] prod;
    prod = 20'({c, 1'b0}) * 20'(DIV3_MUL);
    return prod[DIV3_SH +: COL_W];
  endfunction

  function automatic logic [COL_W-1:0] absdiff(input logic [COL_W-1:0] a,
                                               input logic [COL_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> hw/rtl/psnm_ram.sv
// generic single write port ram with registered read
module psnm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/palette_shade_nearest_match_top.sv
// palette store with shade table rebuild by nearest l1 colour search
//
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_ready_o  | in_data_i  (psnm_pkg::in_t)
// out     | out | out_valid_o/out_ready_i| out_data_o (psnm_pkg::out_t)
//
// write: taken in idle, result registered; shade or entry read: through ST_READ (one palette or shade ram read)
// rebuild: per entry a fetch, a darken and a scan over all PALETTE_ENTRIES entries,
//   by one distance unit reading the palette ram once per cycle
// after reset a clearing pass over all PALETTE_ENTRIES addresses zeroes both rams, no item taken
// an item is taken only when the output register is empty or being emptied
`include "palette_shade_nearest_match_top_macros.svh"

module palette_shade_nearest_match_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  psnm_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output psnm_pkg::out_t  out_data_o
);

  localparam logic [psnm_pkg::PAL_AW-1:0] LastIdx =
    psnm_pkg::PAL_AW'(psnm_pkg::PALETTE_ENTRIES - 1);
  localparam logic [8:0] EntriesW = 9'(psnm_pkg::PALETTE_ENTRIES);

  psnm_pkg::state_e state_q, state_d;

  logic [psnm_pkg::PAL_AW-1:0] clr_q;
  logic [psnm_pkg::PAL_AW-1:0] t_q;
  logic [psnm_pkg::PAL_AW-1:0] z_q;
  logic [psnm_pkg::PAL_AW-1:0] best_q, best_d;
  logic [psnm_pkg::DIST_W-1:0] bestd_q, bestd_d;
  psnm_pkg::rgb_t              dark_q;
  psnm_pkg::action_e           act_q;
  logic                        ok_q;
  logic                        out_valid_q;
  psnm_pkg::out_t              out_q;

  logic in_acc;
  logic in_ok;
  logic out_free;

  logic                        pal_we;
  logic [psnm_pkg::PAL_AW-1:0] pal_waddr;
  psnm_pkg::rgb_t              pal_wdata;
  logic [psnm_pkg::PAL_AW-1:0] pal_raddr;
  psnm_pkg::rgb_t              pal_rdata;
  logic                        shd_we;
  logic [psnm_pkg::PAL_AW-1:0] shd_waddr;
  logic [7:0]                  shd_wdata;
  logic [psnm_pkg::PAL_AW-1:0] shd_raddr;
  logic [7:0]                  shd_rdata;

  logic [psnm_pkg::DIST_W-1:0] dist_sum;
  logic                        take;

  psnm_ram #(
    .Width($bits(psnm_pkg::rgb_t)),
    .Depth(psnm_pkg::PALETTE_ENTRIES)
  ) u_pal_ram (
    .clk_i,
    .we_i   (pal_we),
    .waddr_i(pal_waddr),
    .wdata_i(pal_wdata),
    .raddr_i(pal_raddr),
    .rdata_o(pal_rdata)
  );

  psnm_ram #(
    .Width(8),
    .Depth(psnm_pkg::PALETTE_ENTRIES)
  ) u_shd_ram (
    .clk_i,
    .we_i   (shd_we),
    .waddr_i(shd_waddr),
    .wdata_i(shd_wdata),
    .raddr_i(shd_raddr),
    .rdata_o(shd_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && in_ready_o;
  assign in_ok    = {1'b0, in_data_i.index} < EntriesW;

  // shared distance unit
  always_comb begin
    dist_sum = psnm_pkg::DIST_W'(psnm_pkg::absdiff(dark_q.r, pal_rdata.r))
             + psnm_pkg::DIST_W'(psnm_pkg::absdiff(dark_q.g, pal_rdata.g))
             + psnm_pkg::DIST_W'(psnm_pkg::absdiff(dark_q.b, pal_rdata.b));
    take    = (z_q == '0) || (dist_sum < bestd_q);
    best_d  = take ? z_q : best_q;
    bestd_d = take ? dist_sum : bestd_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      psnm_pkg::ST_CLEAR: begin
        if (clr_q == LastIdx) state_d = psnm_pkg::ST_IDLE;
      end
      psnm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.action)
            psnm_pkg::ACT_WRITE:   state_d = psnm_pkg::ST_IDLE;
            psnm_pkg::ACT_REBUILD: state_d = psnm_pkg::ST_FETCH;
            default:               state_d = psnm_pkg::ST_READ;
          endcase
        end
      end
      psnm_pkg::ST_READ:   state_d = psnm_pkg::ST_IDLE;
      psnm_pkg::ST_FETCH:  state_d = psnm_pkg::ST_DARKEN;
      psnm_pkg::ST_DARKEN: state_d = psnm_pkg::ST_SCAN;
      psnm_pkg::ST_SCAN: begin
        if (z_q == LastIdx) begin
          state_d = (t_q == LastIdx) ? psnm_pkg::ST_IDLE : psnm_pkg::ST_FETCH;
        end
      end
      default: state_d = psnm_pkg::ST_CLEAR;
    endcase
  end

  // ram controls and handshake
  always_comb begin
    in_ready_o = 1'b0;
    pal_we     = 1'b0;
    pal_waddr  = in_data_i.index[psnm_pkg::PAL_AW-1:0];
    pal_wdata  = '{r: in_data_i.red_in, g: in_data_i.green_in, b: in_data_i.blue_in};
    pal_raddr  = in_data_i.index[psnm_pkg::PAL_AW-1:0];
    shd_we     = 1'b0;
    shd_waddr  = t_q;
    shd_wdata  = 8'(best_d);
    shd_raddr  = in_data_i.index[psnm_pkg::PAL_AW-1:0];
    case (state_q)
      psnm_pkg::ST_CLEAR: begin
        pal_we    = 1'b1;
        pal_waddr = clr_q;
        pal_wdata = '0;
        shd_we    = 1'b1;
        shd_waddr = clr_q;
        shd_wdata = '0;
      end
      psnm_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        pal_we     = in_acc && (in_data_i.action == psnm_pkg::ACT_WRITE) && in_ok;
      end
      psnm_pkg::ST_FETCH:  pal_raddr = t_q;
      psnm_pkg::ST_DARKEN: pal_raddr = '0;
      psnm_pkg::ST_SCAN: begin
        pal_raddr = z_q + 1'b1;
        shd_we    = (z_q == LastIdx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psnm_pkg::ST_CLEAR;
      clr_q       <= '0;
      t_q         <= '0;
      z_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == psnm_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (in_acc) t_q <= '0;
      if (state_q == psnm_pkg::ST_DARKEN) z_q <= '0;
      if (state_q == psnm_pkg::ST_SCAN) begin
        z_q <= z_q + 1'b1;
        if (z_q == LastIdx) t_q <= t_q + 1'b1;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if ((in_acc && in_data_i.action == psnm_pkg::ACT_WRITE) ||
          (state_q == psnm_pkg::ST_READ) ||
          (state_q == psnm_pkg::ST_SCAN && z_q == LastIdx && t_q == LastIdx)) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= in_data_i.action;
      ok_q  <= in_ok;
    end
    if (state_q == psnm_pkg::ST_DARKEN) begin
      dark_q.r <= psnm_pkg::darken(pal_rdata.r);
      dark_q.g <= psnm_pkg::darken(pal_rdata.g);
      dark_q.b <= psnm_pkg::darken(pal_rdata.b) + psnm_pkg::BLUE_LIFT;
    end
    if (state_q == psnm_pkg::ST_SCAN) begin
      best_q  <= best_d;
      bestd_q <= bestd_d;
    end
    if ((in_acc && in_data_i.action == psnm_pkg::ACT_WRITE) ||
        (state_q == psnm_pkg::ST_SCAN && z_q == LastIdx && t_q == LastIdx)) begin
      out_q <= '0;
    end else if (state_q == psnm_pkg::ST_READ) begin
      out_q <= '0;
      if (ok_q) begin
        case (act_q)
          psnm_pkg::ACT_SHADE: out_q.shade_index <= shd_rdata;
          psnm_pkg::ACT_READ: begin
            out_q.red_out   <= pal_rdata.r;
            out_q.green_out <= pal_rdata.g;
            out_q.blue_out  <= pal_rdata.b;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PSNM_ASSERT(a_no_take_when_blocked, clk_i, rst_ni, (out_valid_o && !out_ready_i) |-> !in_ready_o)
  `PSNM_ASSERT(a_read_slot_free, clk_i, rst_ni, (state_q == psnm_pkg::ST_READ) |-> !out_valid_q)
  `PSNM_ASSERT_NEXT(a_rebuild_starts, clk_i, rst_ni, in_acc && in_data_i.action == psnm_pkg::ACT_REBUILD, state_q == psnm_pkg::ST_FETCH && t_q == '0)
  `PSNM_ASSERT_NEXT(a_scan_steps, clk_i, rst_ni, state_q == psnm_pkg::ST_SCAN && z_q != LastIdx, state_q == psnm_pkg::ST_SCAN && z_q == psnm_pkg::PAL_AW'($past(z_q) + 1'b1))

endmodule

>>> tb/testbench.sv
// self-checking testbench for the palette shade block with nearest colour prediction
module testbench;
  import psnm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASE_ITEMS = 355;

  class shade_scoreboard;
    rgb_t       palette [PALETTE_ENTRIES];
    logic [7:0] shades [PALETTE_ENTRIES];
    out_t       pending_results [$];
    int unsigned errors;

    function new();
      errors = 0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        palette[i] = '0;
        shades[i] = '0;
      end
    endfunction

    function int unsigned span(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void rebuild_shades();
      int unsigned dr, dg, db, dist_sum, best_dist;
      logic [7:0] best;
      for (int t = 0; t < PALETTE_ENTRIES; t++) begin
        dr = int'(palette[t].r) * 8 / 12;
        dg = int'(palette[t].g) * 8 / 12;
        db = int'(palette[t].b) * 8 / 12 + 30;
        best = '0;
        best_dist = 1000;
        for (int z = 0; z < PALETTE_ENTRIES; z++) begin
          dist_sum = span(dr, palette[z].r) + span(dg, palette[z].g) + span(db, palette[z].b);
          if (dist_sum < best_dist) begin
            best_dist = dist_sum;
            best = 8'(z);
          end
        end
        shades[t] = best;
      end
    endfunction

    function void note_item(in_t it);
      out_t res;
      res = '0;
      case (it.action)
        ACT_WRITE: begin
          if (int'(it.index) < PALETTE_ENTRIES)
            palette[it.index] = '{r: it.red_in, g: it.green_in, b: it.blue_in};
        end
        ACT_REBUILD: rebuild_shades();
        ACT_SHADE: begin
          if (int'(it.index) < PALETTE_ENTRIES) res.shade_index = shades[it.index];
        end
        default: begin
          if (int'(it.index) < PALETTE_ENTRIES) begin
            res.red_out = palette[it.index].r;
            res.green_out = palette[it.index].g;
            res.blue_out = palette[it.index].b;
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.shade_index !== exp_res.shade_index) begin
        $display("%0t shade_index mismatch: expected %0d actual %0d", $time,
                 exp_res.shade_index, got.shade_index);
        errors++;
      end
      if (got.red_out !== exp_res.red_out) begin
        $display("%0t red_out mismatch: expected %0d actual %0d", $time,
                 exp_res.red_out, got.red_out);
        errors++;
      end
      if (got.green_out !== exp_res.green_out) begin
        $display("%0t green_out mismatch: expected %0d actual %0d", $time,
                 exp_res.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out !== exp_res.blue_out) begin
        $display("%0t blue_out mismatch: expected %0d actual %0d", $time,
                 exp_res.blue_out, got.blue_out);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;

  shade_scoreboard sb;

  always #5 clk_i = ~clk_i;

  palette_shade_nearest_match_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always @(negedge clk_i) begin
    out_ready <= !recv_idle_en || ($urandom_range(99) >= 30);
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_item(in_data);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_t make_item(action_e act, logic [7:0] idx,
                                    logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_t it;
    it.action = act;
    it.index = idx;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input in_t it);
    int unsigned gap;
    gap = 0;
    if (send_idle_en && $urandom_range(99) < 30) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] random_colour();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int unsigned pick;
    logic [7:0] r, g, b;
    sb = new();
    r = '0;
    g = '0;
    b = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset contents, extremes, a tie between two equal entries, stale shades
    send_item(make_item(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_SHADE, 8'd255, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_WRITE, 8'd0, 8'd255, 8'd255, 8'd255));
    send_item(make_item(ACT_WRITE, 8'd255, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_WRITE, 8'd1, 8'd0, 8'd0, 8'd255));
    send_item(make_item(ACT_WRITE, 8'd2, 8'd170, 8'd170, 8'd200));
    send_item(make_item(ACT_WRITE, 8'd3, 8'd0, 8'd0, 8'd30));
    send_item(make_item(ACT_WRITE, 8'd4, 8'd0, 8'd0, 8'd30));
    send_item(make_item(ACT_WRITE, 8'd128, 8'd128, 8'd64, 8'd32));
    send_item(make_item(ACT_REBUILD, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_SHADE, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_SHADE, 8'd255, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_SHADE, 8'd128, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_SHADE, 8'd3, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_SHADE, 8'd4, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_WRITE, 8'd2, 8'd1, 8'd2, 8'd3));
    send_item(make_item(ACT_SHADE, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_READ, 8'd2, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_READ, 8'd255, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_REBUILD, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(ACT_SHADE, 8'd0, 8'd0, 8'd0, 8'd0));

    // random phases, each closed by a rebuild
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_en = (phase != 1);
      recv_idle_en = (phase != 1);
      if (phase == 2) drain_results();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          // sometimes repeat the last colour so that ties occur
          if ($urandom_range(9) != 0) begin
            r = random_colour();
            g = random_colour();
            b = random_colour();
          end
          send_item(make_item(ACT_WRITE, 8'($urandom_range(255)), r, g, b));
        end else if (pick < 70) begin
          send_item(make_item(ACT_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255))));
        end else begin
          send_item(make_item(ACT_SHADE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255))));
        end
      end
      send_item(make_item(ACT_REBUILD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255))));
    end
    for (int n = 0; n < 12; n++) begin
      send_item(make_item(ACT_SHADE, 8'($urandom_range(255)), 8'd0, 8'd0, 8'd0));
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
